/* hw/rtl/lsps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsps_pkg
// Shared widths, register indexes and constants of the LED status pattern
// sequencer.
// ----------------------------------------------------------------------------
package lsps_pkg;

   // field widths
   localparam int unsigned LEVEL_W   = 8;
   localparam int unsigned GPS_W     = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 8;
   localparam int unsigned PHASE_W   = 4;

   typedef logic [LEVEL_W-1:0]   level_type;
   typedef logic [GPS_W-1:0]     gps_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [CSR_DAT_W-1:0] csr_dat_type;
   typedef logic [PHASE_W-1:0]   phase_type;

   // register indexes
   localparam csr_idx_type CSR_ENABLED   = 3'd0;
   localparam csr_idx_type CSR_BRIGHT    = 3'd1;
   localparam csr_idx_type CSR_DIM       = 3'd2;
   localparam csr_idx_type CSR_OFF       = 3'd3;
   localparam csr_idx_type CSR_FIX3D_THR = 3'd4;
   localparam csr_idx_type CSR_DGPS_THR  = 3'd5;

   // register reset values
   localparam level_type BRIGHT_RESET    = 8'd255;
   localparam level_type DIM_RESET       = 8'd17;
   localparam level_type OFF_RESET       = 8'd0;
   localparam gps_type   FIX3D_THR_RESET = 3'd3;
   localparam gps_type   DGPS_THR_RESET  = 3'd4;

   // phase runs 0 .. PHASE_LAST then wraps
   localparam phase_type PHASE_LAST = 4'd9;

   // one colour
   typedef struct packed {
      level_type red;
      level_type green;
      level_type blue;
   } rgb_type;

endpackage : lsps_pkg
`default_nettype wire

/* hw/rtl/lsps_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsps_if
// Valid/ready channels of the LED status pattern sequencer: status ticks in,
// colour results out, and the register write port.
// ----------------------------------------------------------------------------

// status tick channel
interface lsps_req_if
   import lsps_pkg::*;
   ();
   logic    valid;
   logic    ready;
   logic    initialising;
   logic    calibrating;
   logic    link_power_failsafe;
   logic    gps_failsafe;
   logic    ekf_bad;
   logic    armed;
   logic    prearm_ok;
   gps_type gps_level;
   logic    usb_powered;
   logic    write_accepted;

   modport source (
      output valid, initialising, calibrating, link_power_failsafe, gps_failsafe,
             ekf_bad, armed, prearm_ok, gps_level, usb_powered, write_accepted,
      input  ready
   );
   modport sink (
      input  valid, initialising, calibrating, link_power_failsafe, gps_failsafe,
             ekf_bad, armed, prearm_ok, gps_level, usb_powered, write_accepted,
      output ready
   );
endinterface : lsps_req_if

// colour result channel
interface lsps_rsp_if
   import lsps_pkg::*;
   ();
   logic      valid;
   logic      ready;
   logic      write_request;
   level_type red_level;
   level_type green_level;
   level_type blue_level;

   modport source (
      output valid, write_request, red_level, green_level, blue_level,
      input  ready
   );
   modport sink (
      input  valid, write_request, red_level, green_level, blue_level,
      output ready
   );
endinterface : lsps_rsp_if

// register write channel
interface lsps_csr_if
   import lsps_pkg::*;
   ();
   logic        valid;
   logic        ready;
   csr_idx_type index;
   csr_dat_type data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface : lsps_csr_if
`default_nettype wire

/* hw/rtl/led_status_pattern_sequencer_core.sv */
// timing: each tick item's result is registered in the single result register
// stage; one tick item per cycle is taken while the output register is free or
// drains
// reset: synchronous, active high; clears prescaler, phase and colours and
// loads the register defaults (disabled, bright 255, dim 17, off 0, 3, 4)
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_status_pattern_sequencer_core
// Prescaled ten-phase LED pattern generator driven by vehicle status ticks,
// with write request and latch of the colour accepted by the LED link.
// ----------------------------------------------------------------------------
module led_status_pattern_sequencer_core
   import lsps_pkg::*;
#(
   parameter int unsigned TICK_DIVIDE = 5
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lsps_req_if.sink    req_ch,
   lsps_rsp_if.source  rsp_ch,
   lsps_csr_if.sink    csr_ch
);

   localparam int unsigned DIV_W = $clog2(TICK_DIVIDE + 1);
   localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(TICK_DIVIDE);

   // configuration registers
   logic      enabled_ff;
   level_type bright_ff;
   level_type dim_ff;
   level_type off_ff;
   gps_type   fix3d_thr_ff;
   gps_type   dgps_thr_ff;

   // sequencer state
   logic [DIV_W-1:0] div_ff, div_in;
   phase_type        phase_ff, phase_in;
   rgb_type          want_ff, want_in;
   rgb_type          shown_ff, shown_in;

   // result register
   logic    rsp_valid_ff;
   logic    rsp_req_ff, rsp_req_in;
   rgb_type rsp_rgb_ff;

   logic      take;
   logic      fire;
   logic      fix3d;
   logic      dgps;
   level_type on_lvl;
   level_type off_lvl;
   rgb_type   pat;
   logic      differs;
   logic [DIV_W-1:0] div_inc;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         bright_ff    <= BRIGHT_RESET;
         dim_ff       <= DIM_RESET;
         off_ff       <= OFF_RESET;
         fix3d_thr_ff <= FIX3D_THR_RESET;
         dgps_thr_ff  <= DGPS_THR_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_ENABLED:   enabled_ff   <= csr_ch.data[0];
            CSR_BRIGHT:    bright_ff    <= csr_ch.data;
            CSR_DIM:       dim_ff       <= csr_ch.data;
            CSR_OFF:       off_ff       <= csr_ch.data;
            CSR_FIX3D_THR: fix3d_thr_ff <= csr_ch.data[GPS_W-1:0];
            CSR_DGPS_THR:  dgps_thr_ff  <= csr_ch.data[GPS_W-1:0];
            default: ;
         endcase
      end
   end

   // accept a new item whenever the result register is free or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign take         = req_ch.valid && req_ch.ready;

   // levels and fix quality for this item
   assign on_lvl  = req_ch.usb_powered ? dim_ff : bright_ff;
   assign off_lvl = off_ff;
   assign fix3d   = req_ch.gps_level >= fix3d_thr_ff;
   assign dgps    = req_ch.gps_level >= dgps_thr_ff;

   // prescaler and phase advance
   assign div_inc = div_ff + DIV_W'(1);
   assign fire    = div_inc == DIV_LAST;

   always_comb begin
      div_in   = fire ? '0 : div_inc;
      phase_in = phase_ff;
      if (fire) begin
         phase_in = (phase_ff == PHASE_LAST) ? '0 : phase_ff + PHASE_W'(1);
      end
   end

   // priority chain of patterns, evaluated on the new phase
   always_comb begin
      pat = want_ff;
      if (req_ch.initialising) begin
         pat = phase_in[0] ? rgb_type'{on_lvl, off_lvl, off_lvl}
                           : rgb_type'{off_lvl, off_lvl, on_lvl};
      end else if (req_ch.calibrating) begin
         case (phase_in) inside
            4'd0, 4'd3, 4'd6: pat = '{on_lvl, off_lvl, off_lvl};
            4'd1, 4'd4, 4'd7: pat = '{off_lvl, off_lvl, on_lvl};
            4'd2, 4'd5, 4'd8: pat = '{off_lvl, on_lvl, off_lvl};
            default:          pat = '{off_lvl, off_lvl, off_lvl};
         endcase
      end else if (req_ch.link_power_failsafe || req_ch.gps_failsafe || req_ch.ekf_bad) begin
         if (phase_in < 4'd5) begin
            pat = '{on_lvl, on_lvl, off_lvl};
         end else if (req_ch.gps_failsafe) begin
            pat = '{off_lvl, off_lvl, on_lvl};
         end else if (req_ch.ekf_bad) begin
            pat = '{on_lvl, off_lvl, off_lvl};
         end else begin
            pat = '{off_lvl, off_lvl, off_lvl};
         end
      end else if (req_ch.armed) begin
         pat = fix3d ? rgb_type'{off_lvl, on_lvl, off_lvl}
                     : rgb_type'{off_lvl, off_lvl, on_lvl};
      end else if (!req_ch.prearm_ok) begin
         case (phase_in) inside
            4'd0, 4'd1, 4'd4, 4'd5: pat = '{on_lvl, on_lvl, off_lvl};
            default:                pat = '{off_lvl, off_lvl, off_lvl};
         endcase
      end else if (phase_in == PHASE_LAST) begin
         pat = '{off_lvl, off_lvl, off_lvl};
      end else if (phase_in == 4'd4) begin
         pat = fix3d ? rgb_type'{off_lvl, on_lvl, off_lvl}
                     : rgb_type'{off_lvl, off_lvl, on_lvl};
      end else if (dgps) begin
         // only green moves, blinking on even phases
         case (phase_in) inside
            4'd0, 4'd2, 4'd6, 4'd8: pat.green = on_lvl;
            default:                pat.green = off_lvl;
         endcase
      end
   end

   // desired colour update and write request against the shown colour
   always_comb begin
      want_in    = fire ? pat : want_ff;
      differs    = want_in != shown_ff;
      rsp_req_in = enabled_ff && differs;
      shown_in   = (differs && req_ch.write_accepted) ? want_in : shown_ff;
   end

   // state registers, touched only by enabled items
   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff   <= '0;
         phase_ff <= '0;
         want_ff  <= '0;
         shown_ff <= '0;
      end else if (take && enabled_ff) begin
         div_ff   <= div_in;
         phase_ff <= phase_in;
         want_ff  <= want_in;
         shown_ff <= shown_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_req_ff <= rsp_req_in;
         rsp_rgb_ff <= enabled_ff ? want_in : want_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.write_request = rsp_req_ff;
   assign rsp_ch.red_level     = rsp_rgb_ff.red;
   assign rsp_ch.green_level   = rsp_rgb_ff.green;
   assign rsp_ch.blue_level    = rsp_rgb_ff.blue;

endmodule : led_status_pattern_sequencer_core
`default_nettype wire

/* sim/led_status_pattern_sequencer_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_status_pattern_sequencer_core_test
// Drives status tick items into the sequencer and predicts every colour
// result in step, under register settings from defaults to extremes, with
// free flow, random idling on either side, long output back-pressure and
// pauses that let the pipeline empty.
// ----------------------------------------------------------------------------
module led_status_pattern_sequencer_core_test;
   import lsps_pkg::*;

   localparam int unsigned TICK_DIVIDE    = 5;
   localparam int          CLOCK_PERIOD   = 8;
   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          MAX_GAP        = 40;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          HOLD_CYCLES    = 200;
   localparam phase_type   PHASE_FIX      = 4'd4;
   localparam phase_type   PHASE_HALF     = 4'd5;

   // one status tick item as carried on the input channel
   typedef struct packed {
      logic    initialising;
      logic    calibrating;
      logic    link_power_failsafe;
      logic    gps_failsafe;
      logic    ekf_bad;
      logic    armed;
      logic    prearm_ok;
      gps_type gps_level;
      logic    usb_powered;
      logic    write_accepted;
   } status_tick_type;

   // one colour result item
   typedef struct packed {
      logic    write_request;
      rgb_type colour;
   } colour_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsps_req_if req_ch ();
   lsps_rsp_if rsp_ch ();
   lsps_csr_if csr_ch ();

   led_status_pattern_sequencer_core #(
      .TICK_DIVIDE (TICK_DIVIDE)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // clock
   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // predictor copy of registers and state
   logic      cfg_enabled;
   level_type cfg_bright;
   level_type cfg_dim;
   level_type cfg_off;
   gps_type   cfg_fix3d_thr;
   gps_type   cfg_dgps_thr;
   logic [2:0] prescale;
   phase_type  pattern_phase;
   rgb_type    wanted;
   rgb_type    shown;

   colour_result_type pending_colours [$];
   int mismatch_count = 0;

   // idling controls
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;

   function automatic rgb_type make_colour(level_type r, level_type g, level_type b);
      rgb_type c;
      c.red   = r;
      c.green = g;
      c.blue  = b;
      return c;
   endfunction

   function automatic void reset_pattern_model();
      cfg_enabled   = 1'b0;
      cfg_bright    = BRIGHT_RESET;
      cfg_dim       = DIM_RESET;
      cfg_off       = OFF_RESET;
      cfg_fix3d_thr = FIX3D_THR_RESET;
      cfg_dgps_thr  = DGPS_THR_RESET;
      prescale      = '0;
      pattern_phase = '0;
      wanted        = '0;
      shown         = '0;
   endfunction

   // register write, masked to each register's width
   function automatic void apply_register(csr_idx_type idx, csr_dat_type data);
      case (idx)
         CSR_ENABLED:   cfg_enabled   = data[0];
         CSR_BRIGHT:    cfg_bright    = data;
         CSR_DIM:       cfg_dim       = data;
         CSR_OFF:       cfg_off       = data;
         CSR_FIX3D_THR: cfg_fix3d_thr = data[GPS_W-1:0];
         CSR_DGPS_THR:  cfg_dgps_thr  = data[GPS_W-1:0];
         default: begin
         end
      endcase
   endfunction

   // advance prescaler and phase, rework the wanted colour, decide the write
   function automatic colour_result_type predict_colour(status_tick_type t);
      colour_result_type r;
      level_type lit;
      level_type dark;
      logic has_fix3d;
      logic has_dgps;
      lit       = t.usb_powered ? cfg_dim : cfg_bright;
      dark      = cfg_off;
      has_fix3d = (t.gps_level >= cfg_fix3d_thr);
      has_dgps  = (t.gps_level >= cfg_dgps_thr);
      r.write_request = 1'b0;
      if (cfg_enabled) begin
         if (prescale == 3'(TICK_DIVIDE - 1)) begin
            prescale = '0;
            pattern_phase = (pattern_phase == PHASE_LAST) ? '0 : pattern_phase + 4'd1;
            // priority chain
            if (t.initialising) begin
               wanted = pattern_phase[0] ? make_colour(lit, dark, dark)
                                         : make_colour(dark, dark, lit);
            end else if (t.calibrating) begin
               if (pattern_phase == PHASE_LAST)
                  wanted = make_colour(dark, dark, dark);
               else if (pattern_phase % 4'd3 == 4'd0)
                  wanted = make_colour(lit, dark, dark);
               else if (pattern_phase % 4'd3 == 4'd1)
                  wanted = make_colour(dark, dark, lit);
               else
                  wanted = make_colour(dark, lit, dark);
            end else if (t.link_power_failsafe || t.gps_failsafe || t.ekf_bad) begin
               if (pattern_phase < PHASE_HALF)
                  wanted = make_colour(lit, lit, dark);
               else if (t.gps_failsafe)
                  wanted = make_colour(dark, dark, lit);
               else if (t.ekf_bad)
                  wanted = make_colour(lit, dark, dark);
               else
                  wanted = make_colour(dark, dark, dark);
            end else if (t.armed) begin
               wanted = has_fix3d ? make_colour(dark, lit, dark)
                                  : make_colour(dark, dark, lit);
            end else if (!t.prearm_ok) begin
               if (pattern_phase inside {4'd0, 4'd1, 4'd4, 4'd5})
                  wanted = make_colour(lit, lit, dark);
               else
                  wanted = make_colour(dark, dark, dark);
            end else if (pattern_phase == PHASE_LAST) begin
               wanted = make_colour(dark, dark, dark);
            end else if (pattern_phase == PHASE_FIX) begin
               wanted = has_fix3d ? make_colour(dark, lit, dark)
                                  : make_colour(dark, dark, lit);
            end else if (has_dgps) begin
               // disarmed and ready: only green blinks, the rest keeps its value
               wanted.green = (pattern_phase inside {4'd0, 4'd2, 4'd6, 4'd8}) ? lit : dark;
            end
         end else begin
            prescale = prescale + 3'd1;
         end
         // write request and latch of the accepted colour
         if (wanted != shown) begin
            r.write_request = 1'b1;
            if (t.write_accepted)
               shown = wanted;
         end
      end
      r.colour = wanted;
      return r;
   endfunction

   task automatic note_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
   endtask

   // result side: random stalls, plus a long hold when one is asked for
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // check each result item, predict each tick item, follow register writes
   initial begin
      status_tick_type   seen;
      colour_result_type got;
      colour_result_type want;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
               got.write_request = rsp_ch.write_request;
               got.colour.red    = rsp_ch.red_level;
               got.colour.green  = rsp_ch.green_level;
               got.colour.blue   = rsp_ch.blue_level;
               if (pending_colours.size() == 0) begin
                  note_mismatch("result items pending", 0, 1);
               end else begin
                  want = pending_colours.pop_front();
                  if (got.write_request !== want.write_request)
                     note_mismatch("write_request", want.write_request, got.write_request);
                  if (got.colour.red !== want.colour.red)
                     note_mismatch("red_level", want.colour.red, got.colour.red);
                  if (got.colour.green !== want.colour.green)
                     note_mismatch("green_level", want.colour.green, got.colour.green);
                  if (got.colour.blue !== want.colour.blue)
                     note_mismatch("blue_level", want.colour.blue, got.colour.blue);
               end
            end
            if (req_ch.valid && req_ch.ready) begin
               seen.initialising        = req_ch.initialising;
               seen.calibrating         = req_ch.calibrating;
               seen.link_power_failsafe = req_ch.link_power_failsafe;
               seen.gps_failsafe        = req_ch.gps_failsafe;
               seen.ekf_bad             = req_ch.ekf_bad;
               seen.armed               = req_ch.armed;
               seen.prearm_ok           = req_ch.prearm_ok;
               seen.gps_level           = req_ch.gps_level;
               seen.usb_powered         = req_ch.usb_powered;
               seen.write_accepted      = req_ch.write_accepted;
               pending_colours.push_back(predict_colour(seen));
            end
            if (csr_ch.valid && csr_ch.ready)
               apply_register(csr_ch.index, csr_ch.data);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL led_status_pattern_sequencer_core");
      $finish;
   end

   // offer one tick item after a random gap, return at the edge it is taken
   task automatic send_tick(input status_tick_type t);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.initialising        <= t.initialising;
      req_ch.calibrating         <= t.calibrating;
      req_ch.link_power_failsafe <= t.link_power_failsafe;
      req_ch.gps_failsafe        <= t.gps_failsafe;
      req_ch.ekf_bad             <= t.ekf_bad;
      req_ch.armed               <= t.armed;
      req_ch.prearm_ok           <= t.prearm_ok;
      req_ch.gps_level           <= t.gps_level;
      req_ch.usb_powered         <= t.usb_powered;
      req_ch.write_accepted      <= t.write_accepted;
      req_ch.valid               <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_ticks(input status_tick_type t, input int count);
      repeat (count) send_tick(t);
   endtask

   // stop offering and wait for every predicted colour to come back
   task automatic finish_phase();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_colours.size() != 0);
   endtask

   // write all six registers, then the unused indexes with junk
   task automatic program_registers(input csr_dat_type en, input csr_dat_type br,
                                    input csr_dat_type dm, input csr_dat_type of,
                                    input csr_dat_type f3, input csr_dat_type dg);
      csr_dat_type vals [1 << CSR_IDX_W];
      int i;
      finish_phase();
      vals[CSR_ENABLED]   = en;
      vals[CSR_BRIGHT]    = br;
      vals[CSR_DIM]       = dm;
      vals[CSR_OFF]       = of;
      vals[CSR_FIX3D_THR] = f3;
      vals[CSR_DGPS_THR]  = dg;
      for (i = CSR_DGPS_THR + 1; i < (1 << CSR_IDX_W); i++)
         vals[i] = csr_dat_type'($urandom);
      for (i = 0; i < (1 << CSR_IDX_W); i++) begin
         csr_ch.index <= csr_idx_type'(i);
         csr_ch.data  <= vals[i];
         csr_ch.valid <= 1'b1;
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
   endtask

   task automatic program_random_registers();
      program_registers(csr_dat_type'($urandom_range(99) < 85 ? 8'h01 : 8'h00),
                        csr_dat_type'($urandom), csr_dat_type'($urandom),
                        csr_dat_type'($urandom_range(99) < 60 ? 0 : $urandom),
                        csr_dat_type'($urandom), csr_dat_type'($urandom));
   endtask

   // mostly plausible vehicle status, some pure noise
   function automatic status_tick_type random_tick();
      status_tick_type t;
      logic [31:0] raw;
      raw = $urandom;
      if ($urandom_range(99) < 20) begin
         t = raw[$bits(status_tick_type)-1:0];
      end else begin
         t.initialising        = ($urandom_range(99) < 8);
         t.calibrating         = ($urandom_range(99) < 8);
         t.link_power_failsafe = ($urandom_range(99) < 10);
         t.gps_failsafe        = ($urandom_range(99) < 10);
         t.ekf_bad             = ($urandom_range(99) < 10);
         t.armed               = ($urandom_range(99) < 35);
         t.prearm_ok           = ($urandom_range(99) < 60);
         t.gps_level           = gps_type'($urandom_range(7));
         t.usb_powered         = ($urandom_range(99) < 30);
         t.write_accepted      = ($urandom_range(99) < 75);
      end
      return t;
   endfunction

   task automatic run_random_ticks(input int count);
      repeat (count) send_tick(random_tick());
   endtask

   // disabled block ignores ticks; register bits beyond width are dropped
   task automatic test_disabled_and_masking();
      send_tick('0);
      send_tick('1);
      program_registers(8'hFE, 8'hFF, 8'h11, 8'h00, 8'hFB, 8'hFC);
      send_tick('1);
   endtask

   // one recompute per branch, with a refused write followed by a retry
   task automatic test_directed_patterns();
      status_tick_type t;
      program_registers(8'h01, 8'hFF, 8'h11, 8'h00, 8'h03, 8'h04);
      // initialising with the link refusing the write
      t = '0;
      t.initialising = 1'b1;
      send_ticks(t, TICK_DIVIDE);
      // calibrating on usb power, write now taken
      t = '0;
      t.calibrating    = 1'b1;
      t.usb_powered    = 1'b1;
      t.write_accepted = 1'b1;
      send_ticks(t, TICK_DIVIDE);
      // disarmed and ready with the best fix: green only
      t = '0;
      t.prearm_ok      = 1'b1;
      t.gps_level      = '1;
      t.write_accepted = 1'b1;
      send_ticks(t, TICK_DIVIDE);
      // armed with no fix
      t = '0;
      t.armed          = 1'b1;
      t.write_accepted = 1'b1;
      send_ticks(t, TICK_DIVIDE);
      // gps failsafe in the second half of the cycle
      t = '0;
      t.gps_failsafe   = 1'b1;
      t.ekf_bad        = 1'b1;
      t.write_accepted = 1'b1;
      send_ticks(t, TICK_DIVIDE);
   endtask

   task automatic test_free_flow();
      program_registers(8'h01, 8'hFF, 8'h11, 8'h00, 8'h03, 8'h04);
      send_idle_pct = 0;
      stall_pct     = 0;
      run_random_ticks(150);
   endtask

   task automatic test_sender_idle();
      program_registers(8'h01, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h07);
      send_idle_pct = 68;
      stall_pct     = 0;
      run_random_ticks(120);
   endtask

   task automatic test_receiver_stall();
      program_registers(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h07, 8'h00);
      send_idle_pct = 0;
      stall_pct     = 68;
      run_random_ticks(120);
   endtask

   task automatic test_both_idle();
      send_idle_pct = 11;
      stall_pct     = 11;
      repeat (4) begin
         program_random_registers();
         run_random_ticks(30);
      end
   endtask

   // long output hold while ticks keep coming, so the input backs up
   task automatic test_back_pressure();
      program_registers(8'h01, 8'hC3, 8'h3C, 8'h05, 8'h03, 8'h04);
      send_idle_pct = 0;
      stall_pct     = 0;
      @(negedge clock);
      hold_left = HOLD_CYCLES;
      @(posedge clock);
      run_random_ticks(40);
   endtask

   // short bursts, each left to drain completely
   task automatic test_drain_pauses();
      send_idle_pct = 11;
      stall_pct     = 68;
      repeat (6) begin
         run_random_ticks(10);
         finish_phase();
      end
   endtask

   initial begin
      req_ch.valid               <= 1'b0;
      req_ch.initialising        <= 1'b0;
      req_ch.calibrating         <= 1'b0;
      req_ch.link_power_failsafe <= 1'b0;
      req_ch.gps_failsafe        <= 1'b0;
      req_ch.ekf_bad             <= 1'b0;
      req_ch.armed               <= 1'b0;
      req_ch.prearm_ok           <= 1'b0;
      req_ch.gps_level           <= '0;
      req_ch.usb_powered         <= 1'b0;
      req_ch.write_accepted      <= 1'b0;
      csr_ch.valid               <= 1'b0;
      csr_ch.index               <= CSR_ENABLED;
      csr_ch.data                <= '0;
      reset_pattern_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_and_masking();
      test_directed_patterns();
      test_free_flow();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_back_pressure();
      test_drain_pauses();

      // let everything settle, then catch anything extra or missing
      finish_phase();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_colours.size() != 0)
         note_mismatch("result items left over", 0, pending_colours.size());
      if (mismatch_count == 0)
         $display("PASS led_status_pattern_sequencer_core");
      else
         $display("FAIL led_status_pattern_sequencer_core");
      $finish;
   end

endmodule : led_status_pattern_sequencer_core_test

/* led_status_pattern_sequencer_core.f */
hw/rtl/lsps_pkg.sv
hw/rtl/lsps_if.sv
hw/rtl/led_status_pattern_sequencer_core.sv
sim/led_status_pattern_sequencer_core_test.sv
